/* hw/rtl/jsesc_pkg.sv */
// jsesc_pkg: shared types and constants for the json string escaper
// request and result payload structs, unit plan struct, replacement unit text
// no dependencies
package jsesc_pkg;

    localparam logic [15:0] CAP_RESET = 16'd256;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [15:0] written_length;
        logic        truncated;
        logic        last_of_run;
    } result_t;

    // index 0 is the first byte of the unit
    typedef logic [5:0][7:0] unit_bytes_t;

    typedef struct packed {
        logic        is_end;
        logic [1:0]  repl_count;
        logic [2:0]  fin_len;
        unit_bytes_t fin_bytes;
    } plan_t;

    // backslash u f f f d
    localparam unit_bytes_t REPL_UNIT = {8'h64, 8'h66, 8'h66, 8'h66, 8'h75, 8'h5c};
    localparam logic [2:0]  REPL_LEN  = 3'd6;

endpackage

/* hw/rtl/jsesc_planner.sv */
// jsesc_planner: decodes one request against the buffered utf-8 sequence
// produces the unit plan (replacements, final unit) and keeps the pending bytes
// depends on jsesc_pkg
module jsesc_planner
    import jsesc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item,
    input  logic  load,
    output plan_t plan
);

    logic [2:0][7:0] pend_reg;
    logic [2:0][7:0] pend_next;
    logic [1:0]      pcount_reg;
    logic [1:0]      pcount_next;
    logic [2:0]      exp_reg;
    logic [2:0]      exp_next;

    always_comb
    begin
        logic [7:0] b;
        logic [7:0] lead;
        logic       cont_ok;
        logic       do_lead;
        logic [3:0] nib_hi;
        logic [3:0] nib_lo;

        plan        = '0;
        pend_next   = pend_reg;
        pcount_next = pcount_reg;
        exp_next    = exp_reg;
        do_lead     = 1'b0;
        b           = item.data_byte;
        lead        = pend_reg[0];
        nib_hi      = b[7:4];
        nib_lo      = b[3:0];

        cont_ok = (b[7:6] == 2'b10);
        if (pcount_reg == 2'd1)
        begin
            if ((lead == 8'he0 && b < 8'ha0) || (lead == 8'hed && b >= 8'ha0) ||
                (lead == 8'hf0 && b < 8'h90) || (lead == 8'hf4 && b >= 8'h90))
            begin
                cont_ok = 1'b0;
            end
        end

        if (item.operation == OP_END)
        begin
            plan.is_end     = 1'b1;
            plan.repl_count = pcount_reg;
            pcount_next     = 2'd0;
            exp_next        = 3'd0;
        end
        else if (pcount_reg == 2'd0)
        begin
            do_lead = 1'b1;
        end
        else if (!cont_ok)
        begin
            plan.repl_count = pcount_reg;
            pcount_next     = 2'd0;
            exp_next        = 3'd0;
            do_lead         = 1'b1;
        end
        else if ({1'b0, pcount_reg} + 3'd1 >= exp_reg)
        begin
            plan.fin_len      = {1'b0, pcount_reg} + 3'd1;
            plan.fin_bytes[0] = pend_reg[0];
            plan.fin_bytes[1] = (pcount_reg == 2'd1) ? b : pend_reg[1];
            plan.fin_bytes[2] = (pcount_reg == 2'd2) ? b : pend_reg[2];
            plan.fin_bytes[3] = b;
            pcount_next       = 2'd0;
            exp_next          = 3'd0;
        end
        else
        begin
            pend_next[pcount_reg] = b;
            pcount_next           = pcount_reg + 2'd1;
        end

        if (do_lead)
        begin
            if (b == 8'h22 || b == 8'h5c)
            begin
                plan.fin_len      = 3'd2;
                plan.fin_bytes[0] = 8'h5c;
                plan.fin_bytes[1] = b;
            end
            else if (b == 8'h0a || b == 8'h0d || b == 8'h09)
            begin
                plan.fin_len      = 3'd2;
                plan.fin_bytes[0] = 8'h5c;
                plan.fin_bytes[1] = (b == 8'h0a) ? 8'h6e : ((b == 8'h0d) ? 8'h72 : 8'h74);
            end
            else if (b < 8'h20)
            begin
                plan.fin_len      = 3'd6;
                plan.fin_bytes[0] = 8'h5c;
                plan.fin_bytes[1] = 8'h75;
                plan.fin_bytes[2] = 8'h30;
                plan.fin_bytes[3] = 8'h30;
                plan.fin_bytes[4] = (nib_hi < 4'd10) ? 8'h30 + {4'd0, nib_hi}
                                                     : 8'h57 + {4'd0, nib_hi};
                plan.fin_bytes[5] = (nib_lo < 4'd10) ? 8'h30 + {4'd0, nib_lo}
                                                     : 8'h57 + {4'd0, nib_lo};
            end
            else if (b < 8'h80)
            begin
                plan.fin_len      = 3'd1;
                plan.fin_bytes[0] = b;
            end
            else if (b inside {[8'hc2:8'hf4]})
            begin
                pend_next[0] = b;
                pcount_next  = 2'd1;
                exp_next     = (b <= 8'hdf) ? 3'd2 : ((b <= 8'hef) ? 3'd3 : 3'd4);
            end
            else
            begin
                plan.fin_len   = REPL_LEN;
                plan.fin_bytes = REPL_UNIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= 2'd0;
            exp_reg    <= 3'd0;
        end
        else if (load)
        begin
            pcount_reg <= pcount_next;
            exp_reg    <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pend_reg <= pend_next;
        end
    end

endmodule

/* hw/rtl/jsesc_emitter.sv */
// jsesc_emitter: walks one unit plan a byte per unstalled cycle into the result register
// applies the capacity fit check per unit, tracks written length and stop flag
// depends on jsesc_pkg
module jsesc_emitter
    import jsesc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  plan_t       plan,
    input  logic        plan_valid,
    output logic        load,
    input  logic [15:0] capacity,
    output result_t     result,
    output logic        result_valid,
    input  logic        result_ready
);

    logic        busy_reg;
    logic        busy_next;
    plan_t       cur_reg;
    plan_t       cur_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic [15:0] bw_reg;
    logic [15:0] bw_next;
    logic        stopped_reg;
    logic        stopped_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;
    result_t     out_next;

    always_comb
    begin
        logic        advance;
        logic        in_repl;
        logic [2:0]  unit_len;
        logic [7:0]  unit_byte;
        logic [2:0]  next_len;
        logic        fits;
        logic        next_fits;
        logic        unit_end;
        logic        done;
        logic        emit;
        result_t     res;

        advance   = !out_valid_reg || result_ready;
        in_repl   = (cur_reg.repl_count != 2'd0);
        unit_len  = in_repl ? REPL_LEN : cur_reg.fin_len;
        unit_byte = in_repl ? REPL_UNIT[idx_reg] : cur_reg.fin_bytes[idx_reg];
        next_len  = in_repl ? ((cur_reg.repl_count != 2'd1) ? REPL_LEN : cur_reg.fin_len)
                            : 3'd0;
        fits      = ({1'b0, bw_reg} + {14'd0, unit_len}) < {1'b0, capacity};
        next_fits = ({1'b0, bw_reg} + 17'd1 + {14'd0, next_len}) < {1'b0, capacity};
        unit_end  = (idx_reg == unit_len - 3'd1);

        busy_next      = busy_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        bw_next        = bw_reg;
        stopped_next   = stopped_reg;
        done           = 1'b0;
        emit           = 1'b0;
        res            = '0;

        if (busy_reg && advance)
        begin
            if (!in_repl && cur_reg.is_end)
            begin
                // end of string summary
                emit               = 1'b1;
                res.written_length = bw_reg;
                res.truncated      = stopped_reg;
                res.last_of_run    = 1'b1;
                bw_next            = 16'd0;
                stopped_next       = 1'b0;
                done               = 1'b1;
            end
            else if (unit_len == 3'd0)
            begin
                done = 1'b1;
            end
            else if (idx_reg == 3'd0 && (stopped_reg || !fits))
            begin
                // unit does not fit: nothing more is written for this string
                stopped_next = 1'b1;
                if (cur_reg.is_end)
                begin
                    cur_next.repl_count = 2'd0;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            else
            begin
                emit               = 1'b1;
                res.out_byte       = unit_byte;
                res.byte_valid     = 1'b1;
                res.written_length = bw_reg + 16'd1;
                res.last_of_run    = !cur_reg.is_end && unit_end &&
                                     (next_len == 3'd0 || !next_fits);
                bw_next            = bw_reg + 16'd1;
                if (unit_end)
                begin
                    idx_next = 3'd0;
                    if (in_repl)
                    begin
                        cur_next.repl_count = cur_reg.repl_count - 2'd1;
                        if (!cur_reg.is_end && cur_reg.repl_count == 2'd1 &&
                            cur_reg.fin_len == 3'd0)
                        begin
                            done = 1'b1;
                        end
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end

        load = plan_valid && (!busy_reg || done);
        if (load)
        begin
            busy_next = 1'b1;
            cur_next  = plan;
            idx_next  = 3'd0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 3'd0;
            bw_reg        <= 16'd0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            bw_reg        <= bw_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

/* hw/rtl/json_string_escaper_utf8_check_core.sv */
// json_string_escaper_utf8_check_core: json string escaper with utf-8 check
// first result passes input register, emitter plan register, result register
// one request per cycle if it gives at most one result and results are taken;
// otherwise the next request waits while the emitter writes and drops its units
// reset clears control state and sets capacity to 256; pending bytes unreset
// depends on jsesc_pkg, jsesc_planner, jsesc_emitter
module json_string_escaper_utf8_check_core
    import jsesc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        capacity_we,
    input  logic [15:0] capacity_wdata
);

    logic        in_valid_reg;
    logic        in_valid_next;
    item_t       in_item_reg;
    logic [15:0] capacity_reg;
    logic        load;
    plan_t       plan;

    assign item_ready = !in_valid_reg || load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && item_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
    end

    jsesc_planner u_planner (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_item_reg),
        .load  (load),
        .plan  (plan)
    );

    jsesc_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .plan         (plan),
        .plan_valid   (in_valid_reg),
        .load         (load),
        .capacity     (capacity_reg),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule
